>>> src/flow_monitor_table_with_aging_defines.svh
// assertion helpers, expect clk and rst in scope of the user
`ifndef FLOW_MONITOR_TABLE_WITH_AGING_DEFINES_SVH
`define FLOW_MONITOR_TABLE_WITH_AGING_DEFINES_SVH

// same-cycle implication
`define FMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fmt_pkg.sv
package fmt_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int PADDR_W = 3;
  localparam logic [7:0] RELOAD_RESET = 8'd60;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // register index, taken from paddr[2]
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_RELOAD = 1'b1;

  typedef enum logic [2:0] {
    OP_RX   = 3'd0,
    OP_DROP = 3'd1,
    OP_TX   = 3'd2,
    OP_TICK = 3'd3,
    OP_READ = 3'd4
  } op_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] rport;
    logic [15:0] lport;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [7:0]  ticks;
    logic [31:0] rx;
    logic [31:0] tx;
    logic [31:0] drop;
  } entry_t;

  // write command into the entry store
  typedef struct packed {
    logic en;
    logic mark_live;
    logic mark_free;
  } wr_cmd_t;

endpackage

>>> src/fmt_req_if.sv
interface fmt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] remote_ip;
  logic [15:0] remote_port;
  logic [15:0] local_port;
  logic [3:0]  read_index;

  modport source (
    output valid, op, remote_ip, remote_port, local_port, read_index,
    input  ready
  );
  modport sink (
    input  valid, op, remote_ip, remote_port, local_port, read_index,
    output ready
  );
endinterface

>>> src/fmt_rsp_if.sv
interface fmt_rsp_if;
  logic        valid;
  logic        ready;
  logic        tracked;
  logic [3:0]  slot;
  logic        entry_live;
  logic [31:0] entry_remote_ip;
  logic [15:0] entry_remote_port;
  logic [15:0] entry_local_port;
  logic [7:0]  entry_timeout;
  logic [31:0] entry_rx_count;
  logic [31:0] entry_tx_count;
  logic [31:0] entry_drop_count;

  modport source (
    output valid, tracked, slot, entry_live, entry_remote_ip, entry_remote_port,
    output entry_local_port, entry_timeout, entry_rx_count, entry_tx_count,
    output entry_drop_count,
    input  ready
  );
  modport sink (
    input  valid, tracked, slot, entry_live, entry_remote_ip, entry_remote_port,
    input  entry_local_port, entry_timeout, entry_rx_count, entry_tx_count,
    input  entry_drop_count,
    output ready
  );
endinterface

>>> src/flow_monitor_table_with_aging.sv
// flow monitor table with timeout aging
// req channel (valid/ready) takes one request: rx, drop, tx, tick or read of one entry.
// rsp channel (valid/ready) returns exactly one result per request, in order.
// config is an apb-style port: monitor_enable at 0x0, timeout_reload at 0x4,
// pready always high, reads return the register.
// rx/drop/tx and tick requests scan all ENTRIES entries of the store, one read
// issued per cycle through the single read port; a tick writes back each live
// entry as its read returns, an event then does one write for the chosen entry.
// an event steps through S_SCAN, S_UPDATE and S_DONE, a tick through S_TICK and
// S_DONE, a read through S_READ, S_RDATA and S_DONE, an ignored request
// (monitoring off, unused op) goes straight to S_DONE.
// one request is worked on at a time; req.ready is high while idle.
// the result sits in an output register, so a new request is taken while it
// waits; a stalled rsp holds the block only when the next result is done.
// reset clears all live flags (every entry free, reads as zero), sets
// monitor_enable to 1 and timeout_reload to 60.
`include "flow_monitor_table_with_aging_defines.svh"

module flow_monitor_table_with_aging #(
  parameter int ENTRIES = fmt_pkg::DEFAULT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  fmt_req_if.sink                    req,
  fmt_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fmt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fmt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SW = (IDX_W > 4) ? IDX_W : 4;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_TICK   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_RDATA  = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic        tracked;
    logic [3:0]  slot;
    logic        live;
    entry_t      ent;
  } res_t;

  state_t state, state_next;

  // config registers
  logic       monitor_enable;
  logic [7:0] timeout_reload;

  // request capture
  op_t        op_q;
  key_t       key_q;
  logic [3:0] ridx_q;

  // scan bookkeeping
  logic [CNT_W-1:0] issue_cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             have_hit, have_free;
  logic [IDX_W-1:0] hit_idx, free_idx;
  entry_t           hit_ent;

  // store port
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  wr_cmd_t          wr_cmd;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [ENTRIES-1:0] live;

  // result path
  res_t res_q;
  res_t rsp_data;
  logic rsp_valid;

  // combinational helpers
  logic             scan_left;
  logic             key_match;
  logic             ridx_in;
  logic [SW-1:0]    ridx_ext;
  logic [IDX_W-1:0] ridx_addr;
  logic [IDX_W-1:0] sel_idx;
  logic [SW-1:0]    sel_ext;
  logic [7:0]       reload_eff;
  entry_t           upd_ent;
  logic             cfg_wr;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  fmt_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_cmd  (wr_cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .live    (live)
  );

  // apb config port, register picked by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_ENABLE: prdata = {31'd0, monitor_enable};
      REG_RELOAD: prdata = {24'd0, timeout_reload};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b1;
      timeout_reload <= RELOAD_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ENABLE: monitor_enable <= pwdata[0];
        REG_RELOAD: timeout_reload <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // index helpers
  assign ridx_ext   = SW'(ridx_q);
  assign ridx_addr  = ridx_ext[IDX_W-1:0];
  assign ridx_in    = 32'(ridx_q) < 32'(ENTRIES);
  assign scan_left  = issue_cnt != CNT_W'(ENTRIES);
  assign key_match  = rd_data.key == key_q;
  assign sel_idx    = have_hit ? hit_idx : free_idx;
  assign sel_ext    = SW'(sel_idx);
  assign reload_eff = (timeout_reload != 8'd0) ? timeout_reload : 8'd1;

  // entry after an event: hit keeps its counters, a claim starts from zero
  always_comb begin
    upd_ent = '0;
    upd_ent.key = key_q;
    if (have_hit) begin
      upd_ent = hit_ent;
    end
    upd_ent.ticks = reload_eff;
    case (op_q)
      OP_RX:   upd_ent.rx   = bump(upd_ent.rx);
      OP_DROP: upd_ent.drop = bump(upd_ent.drop);
      default: upd_ent.tx   = bump(upd_ent.tx);
    endcase
  end

  // next state and store accesses
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = issue_cnt[IDX_W-1:0];
    wr_cmd     = '0;
    wr_addr    = rd_idx;
    wr_data    = rd_data;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.op))
            OP_READ: state_next = S_READ;
            OP_RX, OP_DROP, OP_TX: state_next = monitor_enable ? S_SCAN : S_DONE;
            OP_TICK: state_next = monitor_enable ? S_TICK : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        rd_en = scan_left;
        if (!scan_left && !rd_pend) begin
          state_next = S_UPDATE;
        end
      end
      S_TICK: begin
        rd_en = scan_left;
        // age the entry that came back this cycle, free it at zero
        if (rd_pend && live[rd_idx]) begin
          wr_cmd.en        = 1'b1;
          wr_cmd.mark_free = rd_data.ticks == 8'd1;
          wr_data.ticks    = rd_data.ticks - 8'd1;
        end
        if (!scan_left && !rd_pend) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        rd_addr    = ridx_addr;
        state_next = S_RDATA;
      end
      S_RDATA: begin
        state_next = S_DONE;
      end
      S_UPDATE: begin
        if (have_hit || have_free) begin
          wr_cmd.en        = 1'b1;
          wr_cmd.mark_live = 1'b1;
          wr_addr          = sel_idx;
          wr_data          = upd_ent;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      issue_cnt <= '0;
      have_hit  <= 1'b0;
      have_free <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      rd_idx  <= rd_addr;

      if (state == S_IDLE && req.valid) begin
        op_q      <= op_t'(req.op);
        key_q     <= '{ip: req.remote_ip, rport: req.remote_port, lport: req.local_port};
        ridx_q    <= req.read_index;
        issue_cnt <= '0;
        have_hit  <= 1'b0;
        have_free <= 1'b0;
        res_q     <= '0;
      end

      if ((state == S_SCAN || state == S_TICK) && scan_left) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end

      // search: first live match wins, else lowest free entry
      if (state == S_SCAN && rd_pend) begin
        if (live[rd_idx]) begin
          if (key_match && !have_hit) begin
            have_hit <= 1'b1;
            hit_idx  <= rd_idx;
            hit_ent  <= rd_data;
          end
        end else if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= rd_idx;
        end
      end

      if (state == S_RDATA) begin
        res_q.tracked <= 1'b0;
        res_q.slot    <= ridx_q;
        res_q.live    <= ridx_in && live[rd_idx];
        res_q.ent     <= (ridx_in && live[rd_idx]) ? rd_data : '0;
      end

      if (state == S_UPDATE && (have_hit || have_free)) begin
        res_q.tracked <= 1'b1;
        res_q.slot    <= sel_ext[3:0];
        res_q.live    <= 1'b1;
        res_q.ent     <= upd_ent;
      end

      // output register
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
        rsp_data  <= res_q;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign req.ready = state == S_IDLE;

  assign rsp.valid             = rsp_valid;
  assign rsp.tracked           = rsp_data.tracked;
  assign rsp.slot              = rsp_data.slot;
  assign rsp.entry_live        = rsp_data.live;
  assign rsp.entry_remote_ip   = rsp_data.ent.key.ip;
  assign rsp.entry_remote_port = rsp_data.ent.key.rport;
  assign rsp.entry_local_port  = rsp_data.ent.key.lport;
  assign rsp.entry_timeout     = rsp_data.ent.ticks;
  assign rsp.entry_rx_count    = rsp_data.ent.rx;
  assign rsp.entry_tx_count    = rsp_data.ent.tx;
  assign rsp.entry_drop_count  = rsp_data.ent.drop;

  // checks
  `FMT_ASSERT_NEXT(a_one_request, req.valid && req.ready, !req.ready, "second request taken while busy")
  `FMT_ASSERT_IMPL(a_claim_free, state == S_UPDATE && wr_cmd.en && !have_hit, !live[wr_addr], "claim landed on a live entry")
  `FMT_ASSERT_IMPL(a_free_at_zero, wr_cmd.en && wr_cmd.mark_free, state == S_TICK && wr_data.ticks == 8'd0, "entry freed with time left")
  `FMT_ASSERT_IMPL(a_tracked_live, rsp.valid && rsp.tracked, rsp.entry_live && rsp.entry_timeout != 8'd0, "tracked result not live")

endmodule

>>> src/fmt_store.sv
module fmt_store #(
  parameter int ENTRIES = fmt_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output fmt_pkg::entry_t       rd_data,
  input  fmt_pkg::wr_cmd_t      wr_cmd,
  input  logic [IDX_W-1:0]      wr_addr,
  input  fmt_pkg::entry_t       wr_data,
  output logic [ENTRIES-1:0]    live
);
  import fmt_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_cmd.en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // live flags, cleared on reset; rd_data is not masked for a free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr_cmd.en) begin
      if (wr_cmd.mark_live) begin
        live[wr_addr] <= 1'b1;
      end else if (wr_cmd.mark_free) begin
        live[wr_addr] <= 1'b0;
      end
    end
  end

endmodule
